>>> rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the source token scanner
// token kinds, scan modes, error codes, operator codes; the scanner holds the result record layout
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_DOT     = 6'd7;
    localparam logic [5:0] K_SLASH   = 6'd11;
    localparam logic [5:0] K_STAR    = 6'd12;
    localparam logic [5:0] K_BANG    = 6'd13;
    localparam logic [5:0] K_BANG_EQ = 6'd14;
    localparam logic [5:0] K_EQ      = 6'd15;
    localparam logic [5:0] K_EQ_EQ   = 6'd16;
    localparam logic [5:0] K_GT      = 6'd17;
    localparam logic [5:0] K_GT_EQ   = 6'd18;
    localparam logic [5:0] K_LT      = 6'd19;
    localparam logic [5:0] K_LT_EQ   = 6'd20;
    localparam logic [5:0] K_AND     = 6'd21;
    localparam logic [5:0] K_OR      = 6'd22;
    localparam logic [5:0] K_IDENT   = 6'd23;
    localparam logic [5:0] K_STRING  = 6'd24;
    localparam logic [5:0] K_NUMBER  = 6'd25;
    localparam logic [5:0] K_EOF     = 6'd42;
    localparam logic [5:0] K_ERROR   = 6'd43;

    localparam logic [1:0] E_STRING = 2'd0;
    localparam logic [1:0] E_AMP    = 2'd1;
    localparam logic [1:0] E_BAR    = 2'd2;
    localparam logic [1:0] E_BYTE   = 2'd3;

    localparam logic [2:0] OP_BANG = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_LT   = 3'd2;
    localparam logic [2:0] OP_GT   = 3'd3;
    localparam logic [2:0] OP_AMP  = 3'd4;
    localparam logic [2:0] OP_BAR  = 3'd5;

    typedef enum logic [10:0] {
        M_IDLE   = 11'b00000000001,
        M_SLASH  = 11'b00000000010,
        M_LINEC  = 11'b00000000100,
        M_BLOCK  = 11'b00000001000,
        M_BSTAR  = 11'b00000010000,
        M_IDENT  = 11'b00000100000,
        M_NUM    = 11'b00001000000,
        M_NUMDOT = 11'b00010000000,
        M_FRAC   = 11'b00100000000,
        M_STRING = 11'b01000000000,
        M_OPER   = 11'b10000000000
    } mode_t;

    localparam int MAX_RES = 3;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

>>> rtl/sts_in_if.sv
// ----------------------------------------------------------------------------
// sts_in_if: source byte channel
// valid/ready handshake carrying one source byte and the end flag
// ----------------------------------------------------------------------------
interface sts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink (input valid, input ch, input is_end, output ready);
endinterface

>>> rtl/sts_out_if.sv
// ----------------------------------------------------------------------------
// sts_out_if: token record channel
// valid/ready handshake carrying one token record
// ----------------------------------------------------------------------------
interface sts_out_if #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
);
    logic                   valid;
    logic                   ready;
    logic [5:0]             token_kind;
    logic [1:0]             error_code;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [OFFSET_BITS-1:0] tok_length;
    logic [LINE_BITS-1:0]   tok_line;
    logic                   last;

    modport source (output valid, output token_kind, output error_code, output tok_start,
                    output tok_length, output tok_line, output last, input ready);
    modport sink (input valid, input token_kind, input error_code, input tok_start,
                  input tok_length, input tok_line, input last, output ready);
endinterface

>>> rtl/sts_kw_match.sv
// ----------------------------------------------------------------------------
// sts_kw_match: keyword lookup
// parallel compare of the identifier prefix against the sixteen keywords
// ----------------------------------------------------------------------------
module sts_kw_match
    import sts_pkg::*;
#(
    parameter int KEYWORD_MAX = 7,
    parameter int OFFSET_BITS = 24
) (
    input  logic [KEYWORD_MAX-1:0][7:0] prefix,
    input  logic [OFFSET_BITS-1:0]      len,
    output logic [5:0]                  kind
);
    function automatic logic hit(input logic [KEYWORD_MAX-1:0][7:0] p,
                                 input logic [55:0] w, input int n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            if (i < n && p[i] != w[55-8*i -: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [OFFSET_BITS-1:0] l;
    assign l = len;

    always_comb
    begin
        kind = K_IDENT;
        if (l == OFFSET_BITS'(5) && hit(prefix, {"class", 16'h0}, 5)) kind = 6'd26;
        else if (l == OFFSET_BITS'(4) && hit(prefix, {"else", 24'h0}, 4)) kind = 6'd27;
        else if (l == OFFSET_BITS'(5) && hit(prefix, {"false", 16'h0}, 5)) kind = 6'd28;
        else if (l == OFFSET_BITS'(3) && hit(prefix, {"for", 32'h0}, 3)) kind = 6'd29;
        else if (l == OFFSET_BITS'(3) && hit(prefix, {"fun", 32'h0}, 3)) kind = 6'd30;
        else if (l == OFFSET_BITS'(2) && hit(prefix, {"if", 40'h0}, 2)) kind = 6'd31;
        else if (l == OFFSET_BITS'(3) && hit(prefix, {"nil", 32'h0}, 3)) kind = 6'd32;
        else if (l == OFFSET_BITS'(5) && hit(prefix, {"print", 16'h0}, 5)) kind = 6'd33;
        else if (l == OFFSET_BITS'(7) && hit(prefix, "println", 7)) kind = 6'd34;
        else if (l == OFFSET_BITS'(6) && hit(prefix, {"return", 8'h0}, 6)) kind = 6'd35;
        else if (l == OFFSET_BITS'(5) && hit(prefix, {"super", 16'h0}, 5)) kind = 6'd36;
        else if (l == OFFSET_BITS'(4) && hit(prefix, {"this", 24'h0}, 4)) kind = 6'd37;
        else if (l == OFFSET_BITS'(4) && hit(prefix, {"true", 24'h0}, 4)) kind = 6'd38;
        else if (l == OFFSET_BITS'(3) && hit(prefix, {"var", 32'h0}, 3)) kind = 6'd39;
        else if (l == OFFSET_BITS'(5) && hit(prefix, {"while", 16'h0}, 5)) kind = 6'd40;
        else if (l == OFFSET_BITS'(3) && hit(prefix, {"Num", 32'h0}, 3)) kind = 6'd41;
    end
endmodule

>>> rtl/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexer
// one source byte in per cycle while the result queue can take it, up to three token records out per byte
// ----------------------------------------------------------------------------
// latency: a byte's records appear the cycle after it is accepted
// throughput: one byte per cycle while each byte yields at most one record and the
//   output is ready; a byte yielding several records holds the input until the result
//   queue drains, one record a cycle while the output is ready
// reset: idle mode, offset 0, line 1; result queue empty
// ----------------------------------------------------------------------------
module source_token_scanner
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20,
    parameter int KEYWORD_MAX = 7
) (
    input  logic      clk,
    input  logic      rst_n,
    sts_in_if.sink    in_ch,
    sts_out_if.source out_ch
);
    localparam logic [OFFSET_BITS-1:0] OTOP = '1;
    localparam logic [LINE_BITS-1:0]   LTOP = '1;
    localparam int KW_W = $clog2(KEYWORD_MAX);

    typedef struct packed {
        logic [5:0]             kind;
        logic [1:0]             err;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic                   last;
    } rec_t;

    // scanner state
    mode_t                         mode_reg, mode_next;
    logic [2:0]                    pop_reg, pop_next;
    logic [OFFSET_BITS-1:0]        lstart_reg, lstart_next;
    logic [OFFSET_BITS-1:0]        pos_reg, pos_next;
    logic [LINE_BITS-1:0]          line_reg, line_next;
    logic [KEYWORD_MAX-1:0][7:0]   kw_reg, kw_next;

    // result queue: records of the last accepted byte, drained in order
    rec_t [MAX_RES-1:0] q_reg, q_next;
    logic [1:0]         qn_reg, qn_next;
    logic [1:0]         qh_reg, qh_next;

    rec_t [MAX_RES-1:0] res;
    logic [1:0]         nres;
    logic [OFFSET_BITS-1:0] clen;
    logic [5:0]             kw_kind;
    logic [7:0]             c;
    logic                   fire, drain, empty_after;

    sts_kw_match #(.KEYWORD_MAX(KEYWORD_MAX), .OFFSET_BITS(OFFSET_BITS)) u_kw (
        .prefix(kw_reg),
        .len   (clen),
        .kind  (kw_kind)
    );

    assign c     = in_ch.ch;
    assign clen  = (pos_reg >= lstart_reg) ? pos_reg - lstart_reg : '0;
    assign drain = out_ch.valid && out_ch.ready;
    // input taken when the queue is or becomes empty this cycle
    assign empty_after = (qn_reg == 2'd0) || (drain && (qh_reg + 2'd1 == qn_reg));
    assign in_ch.ready = empty_after;
    assign fire  = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = qn_reg != 2'd0;
    assign out_ch.token_kind = q_reg[qh_reg].kind;
    assign out_ch.error_code = q_reg[qh_reg].err;
    assign out_ch.tok_start  = q_reg[qh_reg].start;
    assign out_ch.tok_length = q_reg[qh_reg].len;
    assign out_ch.tok_line   = q_reg[qh_reg].line;
    assign out_ch.last       = q_reg[qh_reg].last;

    // scanner next state: at most three records per byte
    always_comb
    begin
        logic [OFFSET_BITS-1:0] slen;
        logic [5:0]             single;
        logic                   do_fresh;
        logic                   endf;
        rec_t                   r;

        mode_next   = mode_reg;
        pop_next    = pop_reg;
        lstart_next = lstart_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        kw_next     = kw_reg;
        res         = '0;
        nres        = 2'd0;
        do_fresh    = 1'b0;
        endf        = in_ch.is_end || c == 8'h00;
        slen        = (clen >= OTOP - OFFSET_BITS'(1)) ? OTOP : clen + OFFSET_BITS'(1);
        single      = 6'h3f;
        r           = '0;

        // pending-lexeme records flushed at the end of source or a zero byte, then the end record
        if (endf)
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    r = '{K_SLASH, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                end
                M_IDENT:
                begin
                    r = '{(clen >= OFFSET_BITS'(1) && clen <= OFFSET_BITS'(KEYWORD_MAX))
                          ? kw_kind : K_IDENT, 2'd0, lstart_reg, clen, line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                end
                M_NUM, M_FRAC:
                begin
                    r = '{K_NUMBER, 2'd0, lstart_reg, clen, line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                end
                M_NUMDOT:
                begin
                    r = '{K_NUMBER, 2'd0, lstart_reg,
                          (clen != '0) ? clen - OFFSET_BITS'(1) : '0, line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                    r = '{K_DOT, 2'd0, (pos_reg != '0) ? pos_reg - OFFSET_BITS'(1) : '0,
                          OFFSET_BITS'(1), line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                end
                M_STRING:
                begin
                    r = '{K_ERROR, E_STRING, lstart_reg, '0, line_reg, 1'b0};
                    res[nres] = r; nres = nres + 2'd1;
                end
                M_OPER:
                begin
                    case (pop_reg)
                        OP_BANG: r = '{K_BANG, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                        OP_EQ:   r = '{K_EQ, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                        OP_LT:   r = '{K_LT, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                        OP_GT:   r = '{K_GT, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                        OP_AMP:  r = '{K_ERROR, E_AMP, lstart_reg, '0, line_reg, 1'b0};
                        default: r = '{K_ERROR, E_BAR, lstart_reg, '0, line_reg, 1'b0};
                    endcase
                    res[nres] = r; nres = nres + 2'd1;
                end
                default: ;
            endcase
            r = '{K_EOF, 2'd0, pos_reg, '0, line_reg, 1'b0};
            res[nres] = r; nres = nres + 2'd1;
            mode_next   = M_IDLE;
            pop_next    = OP_BANG;
            lstart_next = '0;
            pos_next    = '0;
            line_next   = LINE_BITS'(1);
        end
        else
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    if (c == "/") mode_next = M_LINEC;
                    else if (c == "*") mode_next = M_BLOCK;
                    else
                    begin
                        r = '{K_SLASH, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_LINEC:
                begin
                    if (c == 8'h0a) do_fresh = 1'b1;
                end
                M_BLOCK, M_BSTAR:
                begin
                    if (c == 8'h0a && line_reg != LTOP) line_next = line_reg + LINE_BITS'(1);
                    if (mode_reg == M_BSTAR && c == "/") mode_next = M_IDLE;
                    else mode_next = (c == "*") ? M_BSTAR : M_BLOCK;
                end
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (clen < OFFSET_BITS'(KEYWORD_MAX)) kw_next[clen[KW_W-1:0]] = c;
                    end
                    else
                    begin
                        r = '{(clen >= OFFSET_BITS'(1) && clen <= OFFSET_BITS'(KEYWORD_MAX))
                              ? kw_kind : K_IDENT, 2'd0, lstart_reg, clen, line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (c == ".") mode_next = M_NUMDOT;
                    else if (!is_digit(c))
                    begin
                        r = '{K_NUMBER, 2'd0, lstart_reg, clen, line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(c)) mode_next = M_FRAC;
                    else
                    begin
                        r = '{K_NUMBER, 2'd0, lstart_reg,
                              (clen != '0) ? clen - OFFSET_BITS'(1) : '0, line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        r = '{K_DOT, 2'd0, (pos_reg != '0) ? pos_reg - OFFSET_BITS'(1) : '0,
                              OFFSET_BITS'(1), line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (!is_digit(c))
                    begin
                        r = '{K_NUMBER, 2'd0, lstart_reg, clen, line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == 8'h22)
                    begin
                        r = '{K_STRING, 2'd0, lstart_reg, slen, line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h0a && line_reg != LTOP)
                    begin
                        line_next = line_reg + LINE_BITS'(1);
                    end
                end
                M_OPER:
                begin
                    if (pop_reg < OP_AMP && c == "=")
                    begin
                        case (pop_reg)
                            OP_BANG: r.kind = K_BANG_EQ;
                            OP_EQ:   r.kind = K_EQ_EQ;
                            OP_LT:   r.kind = K_LT_EQ;
                            default: r.kind = K_GT_EQ;
                        endcase
                        r = '{r.kind, 2'd0, lstart_reg, OFFSET_BITS'(2), line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (pop_reg == OP_AMP && c == "&")
                    begin
                        r = '{K_AND, 2'd0, lstart_reg, OFFSET_BITS'(2), line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (pop_reg == OP_BAR && c == "|")
                    begin
                        r = '{K_OR, 2'd0, lstart_reg, OFFSET_BITS'(2), line_reg, 1'b0};
                        res[nres] = r; nres = nres + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        case (pop_reg)
                            OP_BANG: r = '{K_BANG, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                            OP_EQ:   r = '{K_EQ, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                            OP_LT:   r = '{K_LT, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                            OP_GT:   r = '{K_GT, 2'd0, lstart_reg, OFFSET_BITS'(1), line_reg, 1'b0};
                            OP_AMP:  r = '{K_ERROR, E_AMP, lstart_reg, '0, line_reg, 1'b0};
                            default: r = '{K_ERROR, E_BAR, lstart_reg, '0, line_reg, 1'b0};
                        endcase
                        res[nres] = r; nres = nres + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            // fresh scan of this byte from idle
            if (do_fresh)
            begin
                mode_next = M_IDLE;
                case (c)
                    8'h20, 8'h0d, 8'h09: ;
                    8'h0a:
                    begin
                        if (line_reg != LTOP) line_next = line_reg + LINE_BITS'(1);
                    end
                    default:
                    begin
                        lstart_next = pos_reg;
                        case (c)
                            "(": single = 6'd0;
                            ")": single = 6'd1;
                            "{": single = 6'd2;
                            "}": single = 6'd3;
                            "[": single = 6'd4;
                            "]": single = 6'd5;
                            ",": single = 6'd6;
                            ".": single = 6'd7;
                            "-": single = 6'd8;
                            "+": single = 6'd9;
                            ";": single = 6'd10;
                            "*": single = K_STAR;
                            "!": begin pop_next = OP_BANG; mode_next = M_OPER; end
                            "=": begin pop_next = OP_EQ;   mode_next = M_OPER; end
                            "<": begin pop_next = OP_LT;   mode_next = M_OPER; end
                            ">": begin pop_next = OP_GT;   mode_next = M_OPER; end
                            "&": begin pop_next = OP_AMP;  mode_next = M_OPER; end
                            "|": begin pop_next = OP_BAR;  mode_next = M_OPER; end
                            "/": mode_next = M_SLASH;
                            8'h22: mode_next = M_STRING;
                            default:
                            begin
                                if (is_digit(c)) mode_next = M_NUM;
                                else if (is_alpha(c))
                                begin
                                    kw_next[0] = c;
                                    mode_next  = M_IDENT;
                                end
                                else
                                begin
                                    r = '{K_ERROR, E_BYTE, pos_reg, '0, line_next, 1'b0};
                                    res[nres] = r; nres = nres + 2'd1;
                                end
                            end
                        endcase
                        if (single != 6'h3f)
                        begin
                            r = '{single, 2'd0, pos_reg, OFFSET_BITS'(1), line_next, 1'b0};
                            res[nres] = r; nres = nres + 2'd1;
                        end
                    end
                endcase
            end
            if (pos_reg != OTOP) pos_next = pos_reg + OFFSET_BITS'(1);
        end
        if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
    end

    // queue bookkeeping
    always_comb
    begin
        q_next  = q_reg;
        qn_next = qn_reg;
        qh_next = qh_reg;
        if (drain)
        begin
            qh_next = qh_reg + 2'd1;
            if (qh_reg + 2'd1 == qn_reg)
            begin
                qn_next = 2'd0;
                qh_next = 2'd0;
            end
        end
        if (fire)
        begin
            q_next  = res;
            qn_next = nres;
            qh_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pop_reg    <= OP_BANG;
            lstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            qn_reg     <= 2'd0;
            qh_reg     <= 2'd0;
        end
        else
        begin
            qn_reg <= qn_next;
            qh_reg <= qh_next;
            if (fire)
            begin
                mode_reg   <= mode_next;
                pop_reg    <= pop_next;
                lstart_reg <= lstart_next;
                pos_reg    <= pos_next;
                line_reg   <= line_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (fire) kw_reg <= kw_next;
    end

    // queue count never exceeds three, the most records one byte yields
    a_qn_range: assert property (@(posedge clk) disable iff (!rst_n) qn_reg <= 2'd3)
        else $error("queue count out of range");
    // head stays inside the filled part
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        qn_reg != 2'd0 |-> qh_reg < qn_reg)
        else $error("queue head past fill");
    // line count never drops to zero
    a_line: assert property (@(posedge clk) disable iff (!rst_n) line_reg != '0)
        else $error("line count zero");
    // end of source returns the position to zero
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_ch.is_end |=> pos_reg == '0)
        else $error("position not cleared at end");
endmodule

>>> tb/source_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// source_token_scanner_tb: self-checking bench for the streaming lexer
// feeds source bytes through the input channel, predicts every token record
// and compares each accepted record field by field in arrival order
// ----------------------------------------------------------------------------
module source_token_scanner_tb;
    import sts_pkg::*;

    localparam logic [23:0] POS_TOP  = 24'hFFFFFF;
    localparam logic [19:0] LINE_TOP = 20'hFFFFF;
    localparam int          KW_MAX   = 7;

    // token kinds not named in the package
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_LBRACK = 6'd4;
    localparam logic [5:0] K_RBRACK = 6'd5;
    localparam logic [5:0] K_COMMA  = 6'd6;
    localparam logic [5:0] K_MINUS  = 6'd7 + 6'd1;
    localparam logic [5:0] K_PLUS   = 6'd9;
    localparam logic [5:0] K_SEMI   = 6'd10;
    localparam logic [5:0] K_NONE   = 6'd63;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [23:0] start;
        logic [23:0] len;
        logic [19:0] line;
        logic        last;
    } token_rec_t;

    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        logic       has_tok;
        token_rec_t tok;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sts_in_if  src_if ();
    sts_out_if #(.OFFSET_BITS(24), .LINE_BITS(20)) tok_if ();

    source_token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (src_if.sink),
        .out_ch (tok_if.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // lexer state mirror
    // ------------------------------------------------------------------
    mode_t       lx_mode;
    logic [2:0]  lx_op;
    logic [23:0] lx_start;
    logic [23:0] lx_pos;
    logic [19:0] lx_line;
    logic [7:0]  lx_prefix [KW_MAX];

    token_rec_t  tokens_due [$];
    token_rec_t  step_toks [$];
    int          n_errors = 0;
    int          n_tokens = 0;
    int          n_items = 0;
    bit          calm = 1'b0;

    function automatic void lx_reset();
        lx_mode  = M_IDLE;
        lx_op    = OP_BANG;
        lx_start = '0;
        lx_pos   = '0;
        lx_line  = 20'd1;
    endfunction

    function automatic void push_tok(logic [5:0] k, logic [1:0] e, logic [23:0] s,
                                     logic [23:0] l);
        token_rec_t t;
        t.kind  = k;
        t.err   = e;
        t.start = s;
        t.len   = l;
        t.line  = lx_line;
        t.last  = 1'b0;
        if (step_toks.size() < MAX_RES)
            step_toks.push_back(t);
    endfunction

    function automatic bit alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [23:0] lexeme_len();
        return (lx_pos >= lx_start) ? lx_pos - lx_start : 24'd0;
    endfunction

    function automatic bit prefix_is(string w, int n);
        if (w.len() != n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (lx_prefix[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // keyword lookup on the stored prefix of the identifier
    function automatic void close_ident();
        string       words [16];
        logic [23:0] n;
        logic [5:0]  k;
        words = '{"class", "else", "false", "for", "fun", "if", "nil", "print",
                  "println", "return", "super", "this", "true", "var", "while", "Num"};
        n = lexeme_len();
        k = K_IDENT;
        if (n >= 1 && n <= KW_MAX)
            for (int i = 0; i < 16; i++)
                if (k == K_IDENT && prefix_is(words[i], int'(n)))
                    k = 6'd26 + 6'(i);
        push_tok(k, 2'd0, lx_start, n);
    endfunction

    function automatic void close_num_dot();
        logic [23:0] n;
        n = lexeme_len();
        push_tok(K_NUMBER, 2'd0, lx_start, (n > 0) ? n - 24'd1 : 24'd0);
        push_tok(K_DOT, 2'd0, (lx_pos > 0) ? lx_pos - 24'd1 : 24'd0, 24'd1);
    endfunction

    function automatic void close_oper();
        logic [5:0] singles [4];
        singles = '{K_BANG, K_EQ, K_LT, K_GT};
        if (lx_op < OP_AMP)
            push_tok(singles[lx_op], 2'd0, lx_start, 24'd1);
        else
            push_tok(K_ERROR, (lx_op == OP_AMP) ? E_AMP : E_BAR, lx_start, 24'd0);
    endfunction

    // scan a byte from the idle state
    function automatic void scan_fresh(logic [7:0] c);
        logic [5:0] k;
        lx_mode = M_IDLE;
        k = K_NONE;
        case (c)
            " ", 8'h0d, 8'h09: return;
            8'h0a:
            begin
                if (lx_line < LINE_TOP)
                    lx_line++;
                return;
            end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            "-": k = K_MINUS;
            "+": k = K_PLUS;
            ";": k = K_SEMI;
            "*": k = K_STAR;
            "!": lx_op = OP_BANG;
            "=": lx_op = OP_EQ;
            "<": lx_op = OP_LT;
            ">": lx_op = OP_GT;
            "&": lx_op = OP_AMP;
            "|": lx_op = OP_BAR;
            default: ;
        endcase
        lx_start = lx_pos;
        if (k != K_NONE)
            push_tok(k, 2'd0, lx_pos, 24'd1);
        else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "&" || c == "|")
            lx_mode = M_OPER;
        else if (c == "/")
            lx_mode = M_SLASH;
        else if (c == 8'h22)
            lx_mode = M_STRING;
        else if (digit_c(c))
            lx_mode = M_NUM;
        else if (alpha_c(c))
        begin
            lx_prefix[0] = c;
            lx_mode = M_IDENT;
        end
        else
            push_tok(K_ERROR, E_BYTE, lx_pos, 24'd0);
    endfunction

    // expected records for one accepted byte, queued in order
    function automatic void lex_step(logic [7:0] c, logic is_end);
        logic [5:0]  dbl [4];
        logic [23:0] n;
        dbl = '{K_BANG_EQ, K_EQ_EQ, K_LT_EQ, K_GT_EQ};
        step_toks.delete();
        if (is_end || c == 8'd0)
        begin
            case (lx_mode)
                M_SLASH:       push_tok(K_SLASH, 2'd0, lx_start, 24'd1);
                M_IDENT:       close_ident();
                M_NUM, M_FRAC: push_tok(K_NUMBER, 2'd0, lx_start, lexeme_len());
                M_NUMDOT:      close_num_dot();
                M_STRING:      push_tok(K_ERROR, E_STRING, lx_start, 24'd0);
                M_OPER:        close_oper();
                default: ;
            endcase
            push_tok(K_EOF, 2'd0, lx_pos, 24'd0);
            lx_reset();
        end
        else
        begin
            case (lx_mode)
                M_SLASH:
                    if (c == "/")
                        lx_mode = M_LINEC;
                    else if (c == "*")
                        lx_mode = M_BLOCK;
                    else
                    begin
                        push_tok(K_SLASH, 2'd0, lx_start, 24'd1);
                        scan_fresh(c);
                    end
                M_LINEC:
                    if (c == 8'h0a)
                        scan_fresh(c);
                M_BLOCK, M_BSTAR:
                begin
                    // newlines inside block comments are counted
                    if (c == 8'h0a && lx_line < LINE_TOP)
                        lx_line++;
                    if (lx_mode == M_BSTAR && c == "/")
                        lx_mode = M_IDLE;
                    else
                        lx_mode = (c == "*") ? M_BSTAR : M_BLOCK;
                end
                M_IDENT:
                    if (alpha_c(c) || digit_c(c))
                    begin
                        n = lexeme_len();
                        if (n < KW_MAX)
                            lx_prefix[n] = c;
                    end
                    else
                    begin
                        close_ident();
                        scan_fresh(c);
                    end
                M_NUM:
                    if (c == ".")
                        lx_mode = M_NUMDOT;
                    else if (!digit_c(c))
                    begin
                        push_tok(K_NUMBER, 2'd0, lx_start, lexeme_len());
                        scan_fresh(c);
                    end
                M_NUMDOT:
                    if (digit_c(c))
                        lx_mode = M_FRAC;
                    else
                    begin
                        close_num_dot();
                        scan_fresh(c);
                    end
                M_FRAC:
                    if (!digit_c(c))
                    begin
                        push_tok(K_NUMBER, 2'd0, lx_start, lexeme_len());
                        scan_fresh(c);
                    end
                M_STRING:
                    if (c == 8'h22)
                    begin
                        n = lexeme_len();
                        push_tok(K_STRING, 2'd0, lx_start,
                                 (n >= POS_TOP - 24'd1) ? POS_TOP : n + 24'd1);
                        lx_mode = M_IDLE;
                    end
                    else if (c == 8'h0a && lx_line < LINE_TOP)
                        lx_line++;
                M_OPER:
                    if (lx_op < OP_AMP && c == "=")
                    begin
                        push_tok(dbl[lx_op], 2'd0, lx_start, 24'd2);
                        lx_mode = M_IDLE;
                    end
                    else if (lx_op == OP_AMP && c == "&")
                    begin
                        push_tok(K_AND, 2'd0, lx_start, 24'd2);
                        lx_mode = M_IDLE;
                    end
                    else if (lx_op == OP_BAR && c == "|")
                    begin
                        push_tok(K_OR, 2'd0, lx_start, 24'd2);
                        lx_mode = M_IDLE;
                    end
                    else
                    begin
                        close_oper();
                        scan_fresh(c);
                    end
                default: scan_fresh(c);
            endcase
            if (lx_pos < POS_TOP)
                lx_pos++;
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            tokens_due.push_back(step_toks[i]);
    endfunction

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] c, logic e);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        src_if.valid  <= 1'b1;
        src_if.ch     <= c;
        src_if.is_end <= e;
        // ready is settled at the falling edge ahead of the accepting edge
        @(negedge clk);
        while (!src_if.ready)
            @(negedge clk);
        @(posedge clk);
        lex_step(c, e);
        n_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // a short well-formed fragment with random content
    function automatic string random_lexeme();
        string pool [24];
        string s;
        pool = '{"class", "else", "false", "for", "fun", "if", "nil", "print", "println",
                 "return", "super", "this", "true", "var", "while", "Num", "x_1", "printx",
                 "12.5", "7.", "\"a\nb\"", "/* *\n**/", "// c\n", "&& || != == <= >="};
        s = pool[$urandom_range(0, 23)];
        case ($urandom_range(0, 3))
            0: s = {s, " "};
            1: s = {s, "\n"};
            2: s = {s, ";"};
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // record checker with random stalls
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            token_rec_t got;
            token_rec_t want;
            got = '{tok_if.token_kind, tok_if.error_code, tok_if.tok_start,
                    tok_if.tok_length, tok_if.tok_line, tok_if.last};
            n_tokens++;
            if (tokens_due.size() == 0)
            begin
                $display("%0t: unexpected record, actual %p", $time, got);
                n_errors++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (got.kind != want.kind || got.err != want.err || got.start != want.start
                    || got.len != want.len || got.line != want.line
                    || got.last != want.last)
                begin
                    $display("%0t: record mismatch, expected %p, actual %p",
                             $time, want, got);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            tok_if.ready <= (stall_left == 1);
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 18);
            tok_if.ready <= 1'b0;
        end
        else
            tok_if.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        int        wait_cnt;

        src_if.valid  = 1'b0;
        src_if.ch     = 8'd0;
        src_if.is_end = 1'b0;
        tok_if.ready  = 1'b0;
        lx_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: expected records written out only for the obvious rows
        rows = '{
            '{8'h00, 1'b0, 1'b1, '{K_EOF, 2'd0, 24'd0, 24'd0, 20'd1, 1'b1}},
            '{"@",   1'b0, 1'b1, '{K_ERROR, E_BYTE, 24'd0, 24'd0, 20'd1, 1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{K_ERROR, E_BYTE, 24'd1, 24'd0, 20'd1, 1'b1}},
            '{"&",   1'b0, 1'b0, '0},
            '{" ",   1'b0, 1'b1, '{K_ERROR, E_AMP, 24'd2, 24'd0, 20'd1, 1'b1}},
            '{"|",   1'b0, 1'b0, '0},
            '{"x",   1'b0, 1'b0, '0},
            '{8'h22, 1'b0, 1'b0, '0},
            '{8'h0a, 1'b0, 1'b0, '0},
            '{8'h55, 1'b1, 1'b0, '0},
            '{"1",   1'b0, 1'b0, '0},
            '{".",   1'b0, 1'b0, '0},
            '{"-",   1'b0, 1'b0, '0},
            '{"/",   1'b0, 1'b0, '0},
            '{"*",   1'b0, 1'b0, '0},
            '{8'h0a, 1'b0, 1'b0, '0},
            '{"*",   1'b0, 1'b0, '0},
            '{"/",   1'b0, 1'b0, '0},
            '{"/",   1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.has_tok)
            begin
                // checked against the typed-in record, not the predictor's
                send_byte(r.ch, r.is_end);
                if (tokens_due.size() > 0)
                    tokens_due[tokens_due.size() - 1] = r.tok;
            end
            else
                send_byte(r.ch, r.is_end);
        end
        send_text("( ) { } [ ] , + ; * ! != = == < <= > >= && || ");
        send_text("class println Num return\t\r9.x");
        send_byte(8'h00, 1'b1);
        src_if.valid <= 1'b0;

        // hold off until the scanner has drained everything
        wait_cnt = 0;
        while (tokens_due.size() > 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end

        // random part: mostly well-formed fragments, some raw noise
        while (n_items < 200)
        begin
            if (n_items > 170)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
                2:    send_byte(8'($urandom_range(1, 127)), 1'b0);
                default: send_text(random_lexeme());
            endcase
            if ($urandom_range(0, 30) == 0)
                send_byte(8'h00, 1'($urandom_range(0, 1)));
        end
        send_byte(8'h00, 1'b1);
        src_if.valid <= 1'b0;

        wait_cnt = 0;
        while (tokens_due.size() > 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);

        n_errors += tokens_due.size();
        $display("covered %0d source bytes and %0d token records", n_items, n_tokens);
        $display("operators, keywords, numbers, strings, comments, errors and end marks");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> source_token_scanner.f
rtl/sts_pkg.sv
rtl/sts_in_if.sv
rtl/sts_out_if.sv
rtl/sts_kw_match.sv
rtl/source_token_scanner.sv
tb/source_token_scanner_tb.sv
